// File: design/brle_pkg.sv
`default_nettype none
package brle_pkg;

  localparam int WIDTH_BITS = 12;
  localparam int COL_BITS   = 13;

  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;

  // escape codes following a zero count byte
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOP   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  localparam logic [7:0] NIB_MASK = 8'd15;

  // event queue between decoder and output stage
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_t;

  typedef enum logic [5:0] {
    PH_COUNT = 6'b000001,
    PH_VALUE = 6'b000010,
    PH_DX    = 6'b000100,
    PH_DY    = 6'b001000,
    PH_LIT   = 6'b010000,
    PH_PAD   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic        rle4_mode;
    logic [11:0] image_width;
    logic [11:0] image_height;
  } cfg_t;

  // results caused by one byte: an optional run, then an optional marker
  typedef struct packed {
    logic        has_run;
    logic        has_mark;
    logic [11:0] row;
    logic [12:0] column;
    logic [7:0]  pixel_count;
    logic [7:0]  color_even;
    logic [7:0]  color_odd;
  } ev_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage
`default_nettype wire

// File: design/bmp_rle_decoder.sv
// A taken byte's results are registered in the event queue and read from its head.
// Throughput: one byte per cycle unless full; a byte with run and marker takes two pops.
// The four-entry event queue sets how far input may run ahead of a stalled reader.
// Reset (rst, synchronous): RLE8, width 640, height 480, decoding at column 0 of row 479,
// queue empty.
`default_nettype none
module bmp_rle_decoder import brle_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        restart,
  input  wire logic [7:0]  code_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic             kind,
  output logic [11:0]      row,
  output logic [12:0]      column,
  output logic [7:0]       pixel_count,
  output logic [7:0]       color_even,
  output logic [7:0]       color_odd,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  cfg_t   cfg;
  ev_t    ev, head;
  logic   ev_push, q_pop, take;
  qstat_t qstat;

  assign cfg_ready = 1'b1;
  assign full      = qstat.full;
  assign take      = push && !qstat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rle4_mode    <= 1'b0;
      cfg.image_width  <= WIDTH_RESET;
      cfg.image_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODE:   cfg.rle4_mode    <= cfg_data[0];
        CFG_WIDTH:  cfg.image_width  <= cfg_data;
        CFG_HEIGHT: cfg.image_height <= cfg_data;
        default:    cfg.rle4_mode    <= cfg.rle4_mode;
      endcase
    end
  end

  brle_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .restart   (restart),
    .code_byte (code_byte),
    .ev_push   (ev_push),
    .ev        (ev)
  );

  brle_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (ev_push),
    .wr_ev (ev),
    .rd    (q_pop),
    .head  (head),
    .stat  (qstat)
  );

  brle_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_empty     (qstat.empty),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .kind        (kind),
    .row         (row),
    .column      (column),
    .pixel_count (pixel_count),
    .color_even  (color_even),
    .color_odd   (color_odd),
    .last        (last)
  );

endmodule
`default_nettype wire

// File: design/brle_front.sv
`default_nettype none
module brle_front import brle_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       take,
  input  wire logic       restart,
  input  wire logic [7:0] code_byte,
  output logic            ev_push,
  output ev_t             ev
);

  localparam logic [12:0] DIM_CAP = 13'((MAX_DIM > 4096) ? 4096 : MAX_DIM);
  localparam logic [12:0] ROW_CAP =
    ({1'b0, HEIGHT_RESET} > DIM_CAP) ? DIM_CAP : {1'b0, HEIGHT_RESET};
  localparam logic [11:0] ROW_START = 12'(ROW_CAP - 13'd1);

  phase_t      phase, phase_next, phase_e;
  logic [7:0]  run_count, run_count_next, run_e;
  logic [7:0]  literals_left, literals_left_next, left_e;
  logic        literal_parity, literal_parity_next, parity_e;
  logic [12:0] cur_column, cur_column_next, col_e;
  logic [11:0] cur_row, cur_row_next, row_e;
  logic [7:0]  delta_dx, delta_dx_next, dx_e;
  logic        finished, finished_next, fin_e;

  logic [12:0] w_eff, h_eff;
  logic [13:0] w_lim;
  logic [11:0] start_row;
  logic        four;
  logic        line_chk, line_now, mark, has_run;
  logic [7:0]  cnt, ce, co;
  logic [12:0] row_diff;

  assign four  = cfg.rle4_mode;
  assign w_eff = ({1'b0, cfg.image_width} > DIM_CAP) ? DIM_CAP : {1'b0, cfg.image_width};
  assign w_lim = {1'b0, w_eff} + 14'd1;

  always_comb begin
    h_eff = ({1'b0, cfg.image_height} > DIM_CAP) ? DIM_CAP : {1'b0, cfg.image_height};
    if (h_eff == 13'd0) begin
      h_eff = 13'd1;
    end
    start_row = 12'(h_eff - 13'd1);
  end

  // state as seen by this byte, after an optional restart
  always_comb begin
    if (restart) begin
      phase_e  = PH_COUNT;
      run_e    = '0;
      left_e   = '0;
      parity_e = 1'b0;
      col_e    = '0;
      row_e    = start_row;
      dx_e     = '0;
      fin_e    = 1'b0;
    end else begin
      phase_e  = phase;
      run_e    = run_count;
      left_e   = literals_left;
      parity_e = literal_parity;
      col_e    = cur_column;
      row_e    = cur_row;
      dx_e     = delta_dx;
      fin_e    = finished;
    end
  end

  assign row_diff = {1'b0, row_e} - {5'd0, code_byte};

  always_comb begin
    phase_next          = phase_e;
    run_count_next      = run_e;
    literals_left_next  = left_e;
    literal_parity_next = parity_e;
    cur_column_next     = col_e;
    cur_row_next        = row_e;
    delta_dx_next       = dx_e;
    finished_next       = fin_e;
    line_chk = 1'b0;
    line_now = 1'b0;
    mark     = 1'b0;
    has_run  = 1'b0;
    cnt      = '0;
    ce       = four ? (code_byte >> 4) : code_byte;
    co       = four ? (code_byte & NIB_MASK) : code_byte;
    if (!fin_e) begin
      case (phase_e)
        PH_COUNT: begin
          run_count_next = code_byte;
          phase_next     = PH_VALUE;
        end
        PH_VALUE: begin
          if (run_e != 8'd0) begin
            has_run         = 1'b1;
            cnt             = run_e;
            cur_column_next = col_e + {5'd0, run_e};
            phase_next      = PH_COUNT;
            line_chk        = 1'b1;
          end else if (code_byte == ESC_EOL) begin
            phase_next = PH_COUNT;
            line_now   = 1'b1;
          end else if (code_byte == ESC_EOP) begin
            mark = 1'b1;
          end else if (code_byte == ESC_DELTA) begin
            phase_next = PH_DX;
          end else begin
            literals_left_next  = code_byte;
            literal_parity_next = four ? (code_byte[1] ^ code_byte[0]) : code_byte[0];
            phase_next          = PH_LIT;
          end
        end
        PH_DX: begin
          delta_dx_next = code_byte;
          phase_next    = PH_DY;
        end
        PH_DY: begin
          cur_column_next = col_e + {5'd0, dx_e};
          if (row_diff[12]) begin
            mark = 1'b1;
          end else begin
            cur_row_next = row_diff[11:0];
            phase_next   = PH_COUNT;
            line_chk     = 1'b1;
          end
        end
        PH_LIT: begin
          has_run = 1'b1;
          if (four) begin
            cnt = (left_e >= 8'd2) ? 8'd2 : left_e;
          end else begin
            cnt = 8'd1;
          end
          cur_column_next    = col_e + {5'd0, cnt};
          literals_left_next = left_e - cnt;
          if (literals_left_next == 8'd0) begin
            if (parity_e) begin
              phase_next = PH_PAD;
            end else begin
              phase_next = PH_COUNT;
              line_chk   = 1'b1;
            end
          end
        end
        PH_PAD: begin
          literal_parity_next = 1'b0;
          phase_next          = PH_COUNT;
          line_chk            = 1'b1;
        end
        default: begin
          phase_next = PH_COUNT;
        end
      endcase
    end
    if (line_chk && ({1'b0, cur_column_next} > w_lim)) begin
      line_now = 1'b1;
    end
    if (line_now) begin
      cur_column_next = '0;
      if (cur_row_next == 12'd0) begin
        mark = 1'b1;
      end else begin
        cur_row_next = cur_row_next - 12'd1;
      end
    end
    if (mark) begin
      finished_next = 1'b1;
      phase_next    = PH_COUNT;
    end
  end

  always_comb begin
    ev_push        = take && (has_run || mark);
    ev.has_run     = has_run;
    ev.has_mark    = mark;
    ev.row         = row_e;
    ev.column      = col_e;
    ev.pixel_count = cnt;
    ev.color_even  = ce;
    ev.color_odd   = (cnt == 8'd1) ? ce : co;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_COUNT;
      run_count      <= '0;
      literals_left  <= '0;
      literal_parity <= 1'b0;
      cur_column     <= '0;
      cur_row        <= ROW_START;
      delta_dx       <= '0;
      finished       <= 1'b0;
    end else if (take) begin
      phase          <= phase_next;
      run_count      <= run_count_next;
      literals_left  <= literals_left_next;
      literal_parity <= literal_parity_next;
      cur_column     <= cur_column_next;
      cur_row        <= cur_row_next;
      delta_dx       <= delta_dx_next;
      finished       <= finished_next;
    end
  end

endmodule
`default_nettype wire

// File: design/brle_queue.sv
`default_nettype none
module brle_queue import brle_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire ev_t  wr_ev,
  input  wire logic rd,
  output ev_t       head,
  output qstat_t    stat
);

  ev_t            mem [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0]   count;
  logic           do_wr, do_rd;

  assign stat.full  = (count == (QAW+1)'(QDEPTH));
  assign stat.empty = (count == '0);
  assign do_wr      = wr && !stat.full;
  assign do_rd      = rd && !stat.empty;
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/brle_back.sv
`default_nettype none
module brle_back import brle_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire ev_t   head,
  input  wire logic  q_empty,
  output logic       q_pop,
  input  wire logic  pop,
  output logic       empty,
  output logic       kind,
  output logic [11:0] row,
  output logic [12:0] column,
  output logic [7:0] pixel_count,
  output logic [7:0] color_even,
  output logic [7:0] color_odd,
  output logic       last
);

  logic run_done, run_done_next;
  logic show_mark, take;

  assign empty     = q_empty;
  assign show_mark = head.has_mark && (!head.has_run || run_done);
  assign take      = pop && !q_empty;

  always_comb begin
    kind        = show_mark;
    row         = show_mark ? '0 : head.row;
    column      = show_mark ? '0 : head.column;
    pixel_count = show_mark ? '0 : head.pixel_count;
    color_even  = show_mark ? '0 : head.color_even;
    color_odd   = show_mark ? '0 : head.color_odd;
    last        = show_mark || !head.has_mark;
  end

  // a run followed by a marker leaves the queue after the marker goes
  always_comb begin
    q_pop         = 1'b0;
    run_done_next = run_done;
    if (take) begin
      if (last) begin
        q_pop         = 1'b1;
        run_done_next = 1'b0;
      end else begin
        run_done_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_done <= 1'b0;
    end else begin
      run_done <= run_done_next;
    end
  end

endmodule
`default_nettype wire

// File: design/brle_checker.sv
`default_nettype none
module brle_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        push,
  input wire logic        full,
  input wire logic        restart,
  input wire logic [7:0]  code_byte,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic        kind,
  input wire logic [11:0] row,
  input wire logic [12:0] column,
  input wire logic [7:0]  pixel_count,
  input wire logic [7:0]  color_even,
  input wire logic [7:0]  color_odd,
  input wire logic        last,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [1:0]  cfg_index,
  input wire logic [11:0] cfg_data
);

  a_mark_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind) |-> (row == '0 && column == '0 && pixel_count == '0 &&
                          color_even == '0 && color_odd == '0))
    else $error("marker item carries nonzero fields");

  a_mark_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind) |-> last)
    else $error("marker item not last of its byte");

  a_run_count: assert property (@(posedge clk) disable iff (rst)
    (!empty && !kind) |-> (pixel_count != '0))
    else $error("pixel run with zero count");

  a_single_color: assert property (@(posedge clk) disable iff (rst)
    (!empty && !kind && pixel_count == 8'd1) |-> (color_odd == color_even))
    else $error("single pixel run with differing colors");

  a_mark_follows: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last) |=> (!empty && kind))
    else $error("run not followed by its marker");

endmodule

bind bmp_rle_decoder brle_checker u_chk (.*);
`default_nettype wire
